FILE: rtl/core/crc7_pkg.sv
// Shared types and constants for the bit-serial CRC-7 generator and checker.
package crc7_pkg;

	// Width of the CRC remainder.
	localparam int unsigned CRC_W = 7;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_CRC_MODE      = 2'd0;
	localparam logic [1:0] REG_DATA_LENGTH   = 2'd1;
	localparam logic [1:0] REG_GENERATOR_LOW = 2'd2;

	// Reset values of the configuration registers.
	localparam logic       MODE_RESET = 1'b0;
	localparam logic [9:0] LEN_RESET  = 10'd250;
	localparam logic [6:0] GEN_RESET  = 7'h2D;

	// Result kinds carried on the output tuser.
	localparam logic KIND_CRC_BIT = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Control broadcast to every remainder cell.
	typedef struct packed {
		logic en;    // an input bit updates the remainder this cycle
		logic clr;   // frame start: treat the old remainder as zero
		logic shift; // data bit: shift and apply the generator
		logic fb;    // division feedback bit
		logic inj;   // received CRC bit to fold into one cell
	} cell_ctl_t;

	// Load request for the output stage.
	typedef struct packed {
		logic             load;
		logic             kind;
		logic             pass;
		logic [CRC_W-1:0] bits;
	} out_load_t;

endpackage

FILE: rtl/core/crc7_cell.sv
// One bit of the CRC remainder: shift-and-divide cell of the division chain.
module crc7_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  crc7_pkg::cell_ctl_t ctl,
	input  logic                prev,
	input  logic                coef,
	input  logic                hit,
	output logic                q,
	output logic                d
);
	import crc7_pkg::*;

	logic rem_q;
	logic own_bit;
	logic prev_bit;

	// A frame start makes the cell and its neighbor read as zero.
	assign own_bit  = ctl.clr ? 1'b0 : rem_q;
	assign prev_bit = ctl.clr ? 1'b0 : prev;

	// Next value: shift in the neighbor with generator feedback, or fold in a CRC bit.
	always_comb begin
		if (!ctl.en) begin
			d = rem_q;
		end else if (ctl.shift) begin
			d = prev_bit ^ (ctl.fb & coef);
		end else begin
			d = own_bit ^ (hit & ctl.inj);
		end
	end

	// Remainder bit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 1'b0;
		end else begin
			rem_q <= d;
		end
	end

	assign q = rem_q;

endmodule

FILE: rtl/core/crc7_out.sv
// Output stage: holds a CRC burst or a verdict and shifts it out one transfer at a time.
module crc7_out (
	input  logic                clk,
	input  logic                arst_n,
	input  crc7_pkg::out_load_t req,
	input  logic                ready,
	output logic                valid,
	output logic                bit_out,
	output logic                pass,
	output logic                kind,
	output logic                last
);
	import crc7_pkg::*;

	localparam int unsigned NW = $clog2(CRC_W + 1);

	logic [NW-1:0]    left_q;
	logic [CRC_W-1:0] sr_q;
	logic             kind_q;
	logic             pass_q;

	// Count of results still to deliver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (req.load) begin
			left_q <= (req.kind == KIND_VERDICT) ? NW'(1) : NW'(CRC_W);
		end else if (valid && ready) begin
			left_q <= left_q - NW'(1);
		end
	end

	// Payload: remainder bits leave from the top, highest order first.
	always_ff @(posedge clk) begin
		if (req.load) begin
			sr_q   <= req.bits;
			kind_q <= req.kind;
			pass_q <= req.pass;
		end else if (valid && ready) begin
			sr_q <= {sr_q[CRC_W-2:0], 1'b0};
		end
	end

	assign valid   = (left_q != '0);
	assign last    = (left_q == NW'(1));
	assign kind    = kind_q;
	assign bit_out = (kind_q == KIND_CRC_BIT) ? sr_q[CRC_W-1] : 1'b0;
	assign pass    = (kind_q == KIND_VERDICT) ? pass_q : 1'b0;

endmodule

FILE: rtl/core/crc7_serial_generate_check.sv
// Top level of the bit-serial CRC-7 generator and checker.
//
//  channel   | signals                               | payload
//  ----------+---------------------------------------+------------------------------------
//  input     | s_tvalid s_tready s_tdata s_tuser     | tdata[0] in_bit; tuser frame_start
//  output    | m_tvalid m_tready m_tdata m_tuser     | tdata[0] out_bit, [1] check_pass;
//            | m_tlast                               | tuser result_kind; tlast last
//  config    | cfg_valid cfg_ready cfg_addr cfg_data | index 0 mode, 1 length, 2 generator
//
// Each input bit is folded into the seven-cell remainder chain when taken, so bits stream at
// one per cycle when not held off. A frame end in generate mode loads seven CRC transfers
// into the output stage; a check verdict loads one. Input is held off while that stage is
// busy, except in the cycle its final transfer completes. Reset is asynchronous; after it the
// block behaves as if a frame had just started. Configuration writes are taken in every cycle.
module crc7_serial_generate_check #(
	parameter int unsigned MAX_DATA_BITS = 1023
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [0] in_bit, [7:1] zero
	input  logic       s_tuser,   // [0] frame_start
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] out_bit, [1] check_pass, [7:2] zero
	output logic       m_tuser,   // [0] result_kind
	output logic       m_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_addr,
	input  logic [9:0] cfg_data
);
	import crc7_pkg::*;

	localparam int unsigned CW = $clog2(MAX_DATA_BITS + CRC_W + 1);

	logic             mode_q;
	logic [9:0]       len_cfg_q;
	logic [6:0]       gen_q;
	logic [CW-1:0]    count_q;

	logic             in_fire;
	logic             in_bit;
	logic             start;
	logic [CW-1:0]    cnt_eff;
	logic [CW-1:0]    cnt_next;
	logic [CW-1:0]    len;
	logic [CW-1:0]    total;
	logic             active;
	logic             data_phase;
	logic [2:0]       pos;
	logic [CRC_W-1:0] rem_q;
	logic [CRC_W-1:0] rem_d;
	logic [CRC_W-1:0] hit;
	cell_ctl_t        ctl;
	out_load_t        ld;
	logic             out_valid;
	logic             out_last;
	logic             out_bit;
	logic             out_pass;
	logic             out_kind;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RESET;
			len_cfg_q <= LEN_RESET;
			gen_q     <= GEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_CRC_MODE:      mode_q    <= cfg_data[0];
				REG_DATA_LENGTH:   len_cfg_q <= cfg_data;
				REG_GENERATOR_LOW: gen_q     <= cfg_data[6:0];
				default:           ;
			endcase
		end
	end

	// Effective frame length: zero acts as one, and it is capped at the maximum.
	always_comb begin
		if (len_cfg_q == '0) begin
			len = CW'(1);
		end else if (32'(len_cfg_q) > 32'(MAX_DATA_BITS)) begin
			len = CW'(MAX_DATA_BITS);
		end else begin
			len = CW'(len_cfg_q);
		end
	end

	// Frame position and phase decode for the incoming bit.
	assign in_fire    = s_tvalid && s_tready;
	assign in_bit     = s_tdata[0];
	assign start      = s_tuser;
	assign cnt_eff    = start ? '0 : count_q;
	assign cnt_next   = cnt_eff + CW'(1);
	assign total      = len + (mode_q ? CW'(CRC_W) : '0);
	assign active     = (cnt_eff < total);
	assign data_phase = (cnt_eff < len);
	assign pos        = 3'(cnt_eff - len);

	// Bit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_fire && active) begin
			count_q <= cnt_next;
		end
	end

	// Control shared by all remainder cells.
	always_comb begin
		ctl.en    = in_fire && active;
		ctl.clr   = start;
		ctl.shift = data_phase;
		ctl.fb    = (start ? 1'b0 : rem_q[CRC_W-1]) ^ in_bit;
		ctl.inj   = in_bit;
	end

	// Chain of remainder cells, bit 0 at the low end.
	for (genvar i = 0; i < CRC_W; i++) begin : g_cell
		assign hit[i] = (pos == 3'(CRC_W - 1 - i));
		crc7_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.prev   ((i == 0) ? 1'b0 : rem_q[(i == 0) ? 0 : i - 1]),
			.coef   (gen_q[i]),
			.hit    (hit[i]),
			.q      (rem_q[i]),
			.d      (rem_d[i])
		);
	end

	// Results: CRC burst at the end of data in generate mode, verdict after the CRC in check mode.
	always_comb begin
		ld.load = 1'b0;
		ld.kind = KIND_CRC_BIT;
		ld.pass = 1'b0;
		ld.bits = rem_d;
		if (in_fire && active) begin
			if (data_phase) begin
				ld.load = (cnt_next == len) && !mode_q;
			end else begin
				ld.load = (cnt_next == total);
				ld.kind = KIND_VERDICT;
				ld.pass = (rem_d == '0);
			end
		end
	end

	crc7_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ld),
		.ready   (m_tready),
		.valid   (out_valid),
		.bit_out (out_bit),
		.pass    (out_pass),
		.kind    (out_kind),
		.last    (out_last)
	);

	// Input is taken when the output stage is empty or hands over its final transfer.
	assign s_tready = !out_valid || (out_last && m_tready);

	assign m_tvalid = out_valid;
	assign m_tdata  = {6'b0, out_pass, out_bit};
	assign m_tuser  = out_kind;
	assign m_tlast  = out_last;

endmodule

FILE: rtl/core/crc7_checker.sv
// Port-level checks for the CRC-7 generator and checker, bound to the top level.
module crc7_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);
	import crc7_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// A verdict is a single transfer.
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_VERDICT) |-> m_tlast)
		else $error("verdict not marked last");

	// A verdict carries no CRC bit, and a CRC bit carries no pass flag.
	a_field_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == KIND_VERDICT) ? !m_tdata[0] : !m_tdata[1]))
		else $error("field set for the wrong result kind");

	// Input is only held off while results are pending.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending result");

	// A burst that is not at its last transfer continues in the next cycle.
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == KIND_CRC_BIT))
		else $error("CRC burst broken off");

endmodule

bind crc7_serial_generate_check crc7_checker u_crc7_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
